// File: sv/lesm_pkg.sv
// shared widths, constants and types of the element stiffness block
// no dependencies; used by lesm_div and laplace_element_stiffness_matrix
package lesm_pkg;

    localparam int COORD_W        = 32;
    localparam int GRAD_W         = 33;
    localparam int PROD_W         = 66;
    localparam int QPROD_W        = 64;
    localparam int AREA_W         = 68;
    localparam int FRAC_SHIFT     = 24;
    localparam int NUM_W          = 92;
    localparam int DEN_W          = 68;
    localparam int QUO_W          = 48;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
    localparam int LANES          = 4;

    localparam logic [QUO_W-1:0] ENTRY_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [QUO_W-1:0] ENTRY_MIN_MAG = 48'h8000_0000_0000;

    typedef enum logic {
        KIND_TRI  = 1'b0,
        KIND_QUAD = 1'b1
    } t_kind;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_lane_flags;

    typedef struct packed {
        logic [1:0] row;
        logic       last;
        logic       degen;
    } t_row_tag;

endpackage

// File: sv/lesm_div.sv
// pipelined restoring divider lane, two quotient bits per stage
// depends on lesm_pkg; quotient limited to 48 bits, larger values flagged
module lesm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [lesm_pkg::NUM_W-1:0]    i_num,
    input  logic [lesm_pkg::DEN_W-1:0]    i_den,
    input  lesm_pkg::t_lane_flags         i_flags,
    output logic                          o_valid,
    output logic [lesm_pkg::QUO_W-1:0]    o_quo,
    output logic                          o_sat,
    output lesm_pkg::t_lane_flags         o_flags
);

    localparam int NS = lesm_pkg::DIV_STAGES;
    localparam int DW = lesm_pkg::DEN_W;
    localparam int QW = lesm_pkg::QUO_W;

    logic                  r_vld [0:NS];
    logic [DW-1:0]         r_rem [0:NS];
    logic [QW-1:0]         r_sh  [0:NS];
    logic [DW-1:0]         r_den [0:NS];
    logic                  r_sat [0:NS];
    lesm_pkg::t_lane_flags r_flg [0:NS];

    logic [DW-1:0] n_rem [0:NS];
    logic [QW-1:0] n_sh  [0:NS];
    logic          n_sat0;

    // one shift and conditional subtract
    function automatic logic [DW+QW-1:0] div_step(
        input logic [DW-1:0] rem,
        input logic [QW-1:0] sh,
        input logic [DW-1:0] den
    );
        logic [DW:0] r2;
        logic [DW:0] diff;
        logic        ge;
        r2   = {rem, sh[QW-1]};
        diff = r2 - {1'b0, den};
        ge   = (r2 >= {1'b0, den});
        return {(ge ? diff[DW-1:0] : r2[DW-1:0]), sh[QW-2:0], ge};
    endfunction

    always_comb begin
        logic [DW-1:0] rem;
        logic [QW-1:0] sh;
        n_rem[0] = DW'(i_num[lesm_pkg::NUM_W-1:QW]);
        n_sh[0]  = i_num[QW-1:0];
        n_sat0   = (DW'(i_num[lesm_pkg::NUM_W-1:QW]) >= i_den);
        for (int k = 1; k <= NS; k++) begin
            rem = r_rem[k-1];
            sh  = r_sh[k-1];
            for (int b = 0; b < lesm_pkg::BITS_PER_STAGE; b++) begin
                {rem, sh} = div_step(rem, sh, r_den[k-1]);
            end
            n_rem[k] = rem;
            n_sh[k]  = sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_rem[0];
        r_sh[0]  <= n_sh[0];
        r_den[0] <= i_den;
        r_sat[0] <= n_sat0;
        r_flg[0] <= i_flags;
        for (int k = 1; k <= NS; k++) begin
            r_rem[k] <= n_rem[k];
            r_sh[k]  <= n_sh[k];
            r_den[k] <= r_den[k-1];
            r_sat[k] <= r_sat[k-1];
            r_flg[k] <= r_flg[k-1];
        end
    end

    assign o_valid = r_vld[NS];
    assign o_quo   = r_sh[NS];
    assign o_sat   = r_sat[NS];
    assign o_flags = r_flg[NS];

endmodule

// File: sv/laplace_element_stiffness_matrix.sv
// top level: laplace stiffness matrix of one triangle or quadrilateral element
// depends on lesm_pkg and lesm_div (four divider lanes, one per column)
//
// usage:
//   an item (the corner coordinates) is taken at a clock edge with start high
//   and busy low. element_kind is written on the cfg channel (always ready)
//   while the block is idle; it is sampled when an item is taken.
//   each item gives three rows (triangle) or four rows (quadrilateral), one
//   per cycle, each shown for a single cycle with o_valid high; o_last_row
//   marks the final row. the receiver cannot stall, so nothing downstream of
//   the row sequencer ever holds.
//   pipeline: 37 register stages from the accepting edge to the first row
//   strobe (six front stages for gradients and area, the row register,
//   four stages for dot products and the numerator, 25 divider stages, the
//   output register).
//   the row sequencer issues one row per cycle and takes the next item with
//   the final row of the current one; new items are taken while earlier ones
//   are in flight, and busy is high while the front stages back up behind it.
//   reset clears all valid bits and sets element_kind to triangle.
module laplace_element_stiffness_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    input  logic signed [31:0] i_corner0_x,
    input  logic signed [31:0] i_corner0_y,
    input  logic signed [31:0] i_corner1_x,
    input  logic signed [31:0] i_corner1_y,
    input  logic signed [31:0] i_corner2_x,
    input  logic signed [31:0] i_corner2_y,
    input  logic signed [31:0] i_corner3_x,
    input  logic signed [31:0] i_corner3_y,
    output logic               o_valid,
    output logic [1:0]         o_row_index,
    output logic signed [47:0] o_entry0,
    output logic signed [47:0] o_entry1,
    output logic signed [47:0] o_entry2,
    output logic signed [47:0] o_entry3,
    output logic               o_last_row,
    output logic               o_degenerate
);

    localparam int CW = lesm_pkg::COORD_W;
    localparam int GW = lesm_pkg::GRAD_W;
    localparam int PW = lesm_pkg::PROD_W;
    localparam int QP = lesm_pkg::QPROD_W;
    localparam int AW = lesm_pkg::AREA_W;
    localparam int NW = lesm_pkg::NUM_W;
    localparam int DW = lesm_pkg::DEN_W;
    localparam int QW = lesm_pkg::QUO_W;
    localparam int NL = lesm_pkg::LANES;
    localparam int NS = lesm_pkg::DIV_STAGES;

    // configuration
    lesm_pkg::t_kind r_kind;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= lesm_pkg::KIND_TRI;
        end else if (i_cfg_valid) begin
            r_kind <= lesm_pkg::t_kind'(i_cfg_data);
        end
    end

    // front stage enables, stalled only by the row sequencer
    logic a_en, b_en, c_en, d_en, e_en, f_en, g_ready, accept;

    // stage a: captured corners
    logic                  r_a_valid;
    lesm_pkg::t_kind       r_a_kind;
    logic signed [CW-1:0]  r_a_x [0:3];
    logic signed [CW-1:0]  r_a_y [0:3];

    // stage b: gradients and triangle edge differences
    logic                  r_b_valid;
    lesm_pkg::t_kind       r_b_kind;
    logic signed [CW-1:0]  r_b_x [0:3];
    logic signed [CW-1:0]  r_b_y [0:3];
    logic signed [GW-1:0]  r_b_gx [0:3];
    logic signed [GW-1:0]  r_b_gy [0:3];
    logic signed [GW-1:0]  r_b_dx1, r_b_dy2, r_b_dx2, r_b_dy1;
    logic signed [GW-1:0]  n_b_gx [0:3];
    logic signed [GW-1:0]  n_b_gy [0:3];
    logic signed [GW-1:0]  n_b_dx1, n_b_dy2, n_b_dx2, n_b_dy1;

    // stage c: area products
    logic                  r_c_valid;
    lesm_pkg::t_kind       r_c_kind;
    logic signed [GW-1:0]  r_c_gx [0:3];
    logic signed [GW-1:0]  r_c_gy [0:3];
    logic signed [PW-1:0]  r_c_p0, r_c_p1;
    logic signed [QP-1:0]  r_c_qa [0:3];
    logic signed [QP-1:0]  r_c_qb [0:3];
    logic signed [QP-1:0]  n_c_qa [0:3];
    logic signed [QP-1:0]  n_c_qb [0:3];

    // stage d: shoelace terms and triangle cross product
    logic                  r_d_valid;
    lesm_pkg::t_kind       r_d_kind;
    logic signed [GW-1:0]  r_d_gx [0:3];
    logic signed [GW-1:0]  r_d_gy [0:3];
    logic signed [QP:0]    r_d_t [0:3];
    logic signed [PW:0]    r_d_tri;
    logic signed [QP:0]    n_d_t [0:3];
    logic signed [PW:0]    n_d_tri;

    // stage e: twice the signed area
    logic                  r_e_valid;
    lesm_pkg::t_kind       r_e_kind;
    logic signed [GW-1:0]  r_e_gx [0:3];
    logic signed [GW-1:0]  r_e_gy [0:3];
    logic signed [AW-1:0]  r_e_twoa;
    logic signed [AW-1:0]  n_e_twoa;

    // stage f: area magnitude and sign
    logic                  r_f_valid;
    lesm_pkg::t_kind       r_f_kind;
    logic signed [GW-1:0]  r_f_gx [0:3];
    logic signed [GW-1:0]  r_f_gy [0:3];
    logic [AW-1:0]         r_f_aa;
    logic                  r_f_neg;
    logic                  r_f_degen;
    logic [AW-1:0]         n_f_aa;

    // stage g: row sequencer
    logic                  r_g_valid;
    lesm_pkg::t_kind       r_g_kind;
    logic signed [GW-1:0]  r_g_gx [0:3];
    logic signed [GW-1:0]  r_g_gy [0:3];
    logic [AW-1:0]         r_g_aa;
    logic                  r_g_neg;
    logic                  r_g_degen;
    logic [1:0]            r_g_row;
    logic                  n_g_last;

    assign n_g_last = (r_g_row == ((r_g_kind == lesm_pkg::KIND_QUAD) ? 2'd3 : 2'd2));
    assign g_ready  = !r_g_valid || n_g_last;
    assign f_en     = !r_f_valid || g_ready;
    assign e_en     = !r_e_valid || f_en;
    assign d_en     = !r_d_valid || e_en;
    assign c_en     = !r_c_valid || d_en;
    assign b_en     = !r_b_valid || c_en;
    assign a_en     = !r_a_valid || b_en;
    assign busy     = !a_en;
    assign accept   = start && a_en;

    // stage b logic
    always_comb begin
        logic signed [GW-1:0] xe [0:3];
        logic signed [GW-1:0] ye [0:3];
        for (int i = 0; i < 4; i++) begin
            xe[i] = $signed({r_a_x[i][CW-1], r_a_x[i]});
            ye[i] = $signed({r_a_y[i][CW-1], r_a_y[i]});
        end
        if (r_a_kind == lesm_pkg::KIND_QUAD) begin
            n_b_gx[0] = ye[2] - ye[3];
            n_b_gy[0] = xe[3] - xe[2];
            n_b_gx[1] = ye[3] - ye[0];
            n_b_gy[1] = xe[0] - xe[3];
            n_b_gx[2] = ye[0] - ye[1];
            n_b_gy[2] = xe[1] - xe[0];
            n_b_gx[3] = ye[1] - ye[2];
            n_b_gy[3] = xe[2] - xe[1];
        end else begin
            n_b_gx[0] = ye[1] - ye[2];
            n_b_gy[0] = xe[2] - xe[1];
            n_b_gx[1] = ye[2] - ye[0];
            n_b_gy[1] = xe[0] - xe[2];
            n_b_gx[2] = ye[0] - ye[1];
            n_b_gy[2] = xe[1] - xe[0];
            n_b_gx[3] = '0;
            n_b_gy[3] = '0;
        end
        n_b_dx1 = xe[1] - xe[0];
        n_b_dy2 = ye[2] - ye[0];
        n_b_dx2 = xe[2] - xe[0];
        n_b_dy1 = ye[1] - ye[0];
    end

    // stage c logic: shoelace products x[i]*y[i+1] and x[i+1]*y[i]
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_c_qa[i] = r_b_x[i] * r_b_y[2'(i + 1)];
            n_c_qb[i] = r_b_x[2'(i + 1)] * r_b_y[i];
        end
    end

    // stage d logic
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_d_t[i] = $signed({r_c_qa[i][QP-1], r_c_qa[i]})
                     - $signed({r_c_qb[i][QP-1], r_c_qb[i]});
        end
        n_d_tri = $signed({r_c_p0[PW-1], r_c_p0}) - $signed({r_c_p1[PW-1], r_c_p1});
    end

    // stage e logic
    always_comb begin
        logic signed [AW-1:0] te [0:3];
        for (int i = 0; i < 4; i++) begin
            te[i] = $signed({{(AW-QP-1){r_d_t[i][QP]}}, r_d_t[i]});
        end
        if (r_d_kind == lesm_pkg::KIND_QUAD) begin
            n_e_twoa = (te[0] + te[1]) + (te[2] + te[3]);
        end else begin
            n_e_twoa = $signed({r_d_tri[PW], r_d_tri});
        end
    end

    // stage f logic
    assign n_f_aa = r_e_twoa[AW-1] ? AW'(-r_e_twoa) : AW'(r_e_twoa);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else begin
            if (a_en) begin
                r_a_valid <= accept;
            end
            if (b_en) begin
                r_b_valid <= r_a_valid;
            end
            if (c_en) begin
                r_c_valid <= r_b_valid;
            end
            if (d_en) begin
                r_d_valid <= r_c_valid;
            end
            if (e_en) begin
                r_e_valid <= r_d_valid;
            end
            if (f_en) begin
                r_f_valid <= r_e_valid;
            end
            if (g_ready) begin
                r_g_valid <= r_f_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_kind <= r_kind;
            r_a_x[0] <= i_corner0_x;
            r_a_y[0] <= i_corner0_y;
            r_a_x[1] <= i_corner1_x;
            r_a_y[1] <= i_corner1_y;
            r_a_x[2] <= i_corner2_x;
            r_a_y[2] <= i_corner2_y;
            r_a_x[3] <= i_corner3_x;
            r_a_y[3] <= i_corner3_y;
        end
        if (b_en) begin
            r_b_kind <= r_a_kind;
            r_b_x    <= r_a_x;
            r_b_y    <= r_a_y;
            r_b_gx   <= n_b_gx;
            r_b_gy   <= n_b_gy;
            r_b_dx1  <= n_b_dx1;
            r_b_dy2  <= n_b_dy2;
            r_b_dx2  <= n_b_dx2;
            r_b_dy1  <= n_b_dy1;
        end
        if (c_en) begin
            r_c_kind <= r_b_kind;
            r_c_gx   <= r_b_gx;
            r_c_gy   <= r_b_gy;
            r_c_p0   <= r_b_dx1 * r_b_dy2;
            r_c_p1   <= r_b_dx2 * r_b_dy1;
            r_c_qa   <= n_c_qa;
            r_c_qb   <= n_c_qb;
        end
        if (d_en) begin
            r_d_kind <= r_c_kind;
            r_d_gx   <= r_c_gx;
            r_d_gy   <= r_c_gy;
            r_d_t    <= n_d_t;
            r_d_tri  <= n_d_tri;
        end
        if (e_en) begin
            r_e_kind <= r_d_kind;
            r_e_gx   <= r_d_gx;
            r_e_gy   <= r_d_gy;
            r_e_twoa <= n_e_twoa;
        end
        if (f_en) begin
            r_f_kind  <= r_e_kind;
            r_f_gx    <= r_e_gx;
            r_f_gy    <= r_e_gy;
            r_f_aa    <= n_f_aa;
            r_f_neg   <= r_e_twoa[AW-1];
            r_f_degen <= (r_e_twoa == '0);
        end
        if (g_ready) begin
            r_g_kind  <= r_f_kind;
            r_g_gx    <= r_f_gx;
            r_g_gy    <= r_f_gy;
            r_g_aa    <= r_f_aa;
            r_g_neg   <= r_f_neg;
            r_g_degen <= r_f_degen;
            r_g_row   <= 2'd0;
        end else begin
            r_g_row   <= r_g_row + 2'd1;
        end
    end

    // row pipeline: products, dot, magnitude, numerator
    logic                  r_p_valid;
    lesm_pkg::t_row_tag    r_p_tag;
    logic signed [PW-1:0]  r_p_xx [0:NL-1];
    logic signed [PW-1:0]  r_p_yy [0:NL-1];
    logic [AW-1:0]         r_p_aa;
    logic                  r_p_neg;
    logic                  r_p_zero [0:NL-1];

    logic                  r_s_valid;
    lesm_pkg::t_row_tag    r_s_tag;
    logic signed [AW-1:0]  r_s_dot [0:NL-1];
    logic [AW-1:0]         r_s_aa;
    logic                  r_s_neg;
    logic                  r_s_zero [0:NL-1];

    logic                  r_m_valid;
    lesm_pkg::t_row_tag    r_m_tag;
    logic [AW-1:0]         r_m_ad [0:NL-1];
    logic [AW-1:0]         r_m_aa;
    lesm_pkg::t_lane_flags r_m_flg [0:NL-1];

    logic                  r_n_valid;
    lesm_pkg::t_row_tag    r_n_tag;
    logic [NW-1:0]         r_n_num [0:NL-1];
    logic [DW-1:0]         r_n_den;
    lesm_pkg::t_lane_flags r_n_flg [0:NL-1];

    logic signed [GW-1:0]  n_p_gxr, n_p_gyr;
    lesm_pkg::t_row_tag    n_p_tag;

    assign n_p_gxr       = r_g_gx[r_g_row];
    assign n_p_gyr       = r_g_gy[r_g_row];
    assign n_p_tag.row   = r_g_row;
    assign n_p_tag.last  = n_g_last;
    assign n_p_tag.degen = r_g_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_n_valid <= 1'b0;
        end else begin
            r_p_valid <= r_g_valid;
            r_s_valid <= r_p_valid;
            r_m_valid <= r_s_valid;
            r_n_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_tag <= n_p_tag;
        r_p_aa  <= r_g_aa;
        r_p_neg <= r_g_neg;
        r_s_tag <= r_p_tag;
        r_s_aa  <= r_p_aa;
        r_s_neg <= r_p_neg;
        r_m_tag <= r_s_tag;
        r_m_aa  <= r_s_aa;
        r_n_tag <= r_m_tag;
        r_n_den <= {r_m_aa[AW-2:0], 1'b0};
        for (int j = 0; j < NL; j++) begin
            r_p_xx[j]       <= n_p_gxr * r_g_gx[j];
            r_p_yy[j]       <= n_p_gyr * r_g_gy[j];
            // fourth column of a triangle is empty
            r_p_zero[j]     <= r_g_degen || (r_g_kind == lesm_pkg::KIND_TRI && j == NL - 1);
            r_s_dot[j]      <= $signed({{(AW-PW){r_p_xx[j][PW-1]}}, r_p_xx[j]})
                             + $signed({{(AW-PW){r_p_yy[j][PW-1]}}, r_p_yy[j]});
            r_s_zero[j]     <= r_p_zero[j];
            r_m_ad[j]       <= r_s_dot[j][AW-1] ? AW'(-r_s_dot[j]) : AW'(r_s_dot[j]);
            r_m_flg[j].neg  <= r_s_dot[j][AW-1] ^ r_s_neg;
            r_m_flg[j].zero <= r_s_zero[j];
            // half the divisor added for round to nearest
            r_n_num[j]      <= {r_m_ad[j][NW-lesm_pkg::FRAC_SHIFT-1:0],
                                {lesm_pkg::FRAC_SHIFT{1'b0}}} + NW'(r_m_aa);
            r_n_flg[j]      <= r_m_flg[j];
        end
    end

    // divider lanes, one per column
    logic                  l_valid [0:NL-1];
    logic [QW-1:0]         l_quo   [0:NL-1];
    logic                  l_sat   [0:NL-1];
    lesm_pkg::t_lane_flags l_flg   [0:NL-1];

    for (genvar j = 0; j < NL; j++) begin : g_lane
        lesm_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_n_valid),
            .i_num   (r_n_num[j]),
            .i_den   (r_n_den),
            .i_flags (r_n_flg[j]),
            .o_valid (l_valid[j]),
            .o_quo   (l_quo[j]),
            .o_sat   (l_sat[j]),
            .o_flags (l_flg[j])
        );
    end

    // row tag travels beside the lanes
    lesm_pkg::t_row_tag r_t_tag [0:NS];

    always_ff @(posedge i_clk) begin
        r_t_tag[0] <= r_n_tag;
        for (int k = 1; k <= NS; k++) begin
            r_t_tag[k] <= r_t_tag[k-1];
        end
    end

    function automatic logic [QW-1:0] fix_entry(
        input logic [QW-1:0]         quo,
        input logic                  sat,
        input lesm_pkg::t_lane_flags flg
    );
        logic [QW-1:0] res;
        if (flg.zero) begin
            res = '0;
        end else if (!flg.neg) begin
            res = (sat || quo > lesm_pkg::ENTRY_MAX) ? lesm_pkg::ENTRY_MAX : quo;
        end else if (sat || quo > lesm_pkg::ENTRY_MIN_MAG) begin
            res = lesm_pkg::ENTRY_MIN_MAG;
        end else begin
            res = ~quo + 1'b1;
        end
        return res;
    endfunction

    // output register
    logic                 r_o_valid;
    logic [1:0]           r_o_row;
    logic [QW-1:0]        r_o_entry [0:NL-1];
    logic                 r_o_last;
    logic                 r_o_degen;
    logic                 n_o_valid;

    assign n_o_valid = l_valid[0] && l_valid[1] && l_valid[2] && l_valid[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_row   <= r_t_tag[NS].row;
        r_o_last  <= r_t_tag[NS].last;
        r_o_degen <= r_t_tag[NS].degen;
        for (int j = 0; j < NL; j++) begin
            r_o_entry[j] <= fix_entry(l_quo[j], l_sat[j], l_flg[j]);
        end
    end

    assign o_valid      = r_o_valid;
    assign o_row_index  = r_o_row;
    assign o_entry0     = $signed(r_o_entry[0]);
    assign o_entry1     = $signed(r_o_entry[1]);
    assign o_entry2     = $signed(r_o_entry[2]);
    assign o_entry3     = $signed(r_o_entry[3]);
    assign o_last_row   = r_o_last;
    assign o_degenerate = r_o_degen;

endmodule
